@@ src/mdd_pkg.sv @@
// Shared types and constants for the multichannel NUL-delimited deframer.
package mdd_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int MSG_BYTES_DEF    = 64;

    localparam logic [7:0] NUL_BYTE = 8'h00;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic KIND_MSG  = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_NOTICE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] channel;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    load;
        result_t res;
    } out_req_t;

endpackage

@@ src/mdd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/mdd_out_stage.sv @@
// Result output register between the sequencer and the downstream channel.
module mdd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  mdd_pkg::out_req_t out_req,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [2:0]        m_out_channel,
    output logic [7:0]        m_out_byte,
    output logic              m_last
);

    logic             m_valid_reg;
    logic             m_valid_next;
    mdd_pkg::result_t res_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_req.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_req.load) begin
            res_reg <= out_req.res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = res_reg.kind;
    assign m_out_channel = res_reg.channel;
    assign m_out_byte    = res_reg.data;
    assign m_last        = res_reg.last;

endmodule

@@ src/mdd_ctrl.sv @@
// Sequencer: fill-count read-modify-write, store append, clear, drop notice and message drain.
module mdd_ctrl #(
    parameter int NUM_CHANNELS = mdd_pkg::NUM_CHANNELS_DEF,
    parameter int MSG_BYTES    = mdd_pkg::MSG_BYTES_DEF,
    parameter int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    parameter int POS_W        = $clog2(MSG_BYTES),
    parameter int FILL_W       = $clog2(MSG_BYTES + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic [2:0]              s_channel,
    input  logic [7:0]              s_data_byte,
    output logic                    fill_re,
    output logic [CH_AW-1:0]        fill_raddr,
    input  logic [FILL_W-1:0]       fill_rdata,
    output logic                    fill_we,
    output logic [CH_AW-1:0]        fill_waddr,
    output logic [FILL_W-1:0]       fill_wdata,
    output logic                    store_re,
    output logic [CH_AW+POS_W-1:0]  store_raddr,
    input  logic [7:0]              store_rdata,
    output logic                    store_we,
    output logic [CH_AW+POS_W-1:0]  store_waddr,
    output logic [7:0]              store_wdata,
    input  logic                    out_free,
    output mdd_pkg::out_req_t       out_req
);

    mdd_pkg::state_t state_reg, state_next;

    logic              func_reg;
    logic [2:0]        ch_reg;
    logic [7:0]        byte_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic [NUM_CHANNELS-1:0] fvalid_reg, fvalid_next;

    logic [CH_AW+2:0]  s_ch_wide;
    logic [CH_AW+2:0]  ch_wide;
    logic [CH_AW-1:0]  s_ch_addr;
    logic [CH_AW-1:0]  ch_addr;
    logic              s_in_range;
    logic              accept;
    logic [FILL_W-1:0] fill_now;
    logic              drain_last;

    assign s_ch_wide  = {{CH_AW{1'b0}}, s_channel};
    assign ch_wide    = {{CH_AW{1'b0}}, ch_reg};
    assign s_ch_addr  = s_ch_wide[CH_AW-1:0];
    assign ch_addr    = ch_wide[CH_AW-1:0];
    assign s_in_range = 32'(s_channel) < NUM_CHANNELS;
    assign accept     = s_valid && s_ready;
    assign fill_now   = fvalid_reg[ch_addr] ? fill_rdata : FILL_W'(0);
    assign drain_last = (FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg;

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        fvalid_next = fvalid_reg;

        s_ready     = (state_reg == mdd_pkg::ST_IDLE);
        fill_re     = 1'b0;
        fill_raddr  = s_ch_addr;
        fill_we     = 1'b0;
        fill_waddr  = ch_addr;
        fill_wdata  = FILL_W'(0);
        store_re    = 1'b0;
        store_raddr = {ch_addr, idx_reg};
        store_we    = 1'b0;
        store_waddr = {ch_addr, fill_now[POS_W-1:0]};
        store_wdata = byte_reg;

        out_req.load        = 1'b0;
        out_req.res.kind    = mdd_pkg::KIND_MSG;
        out_req.res.channel = ch_reg;
        out_req.res.data    = store_rdata;
        out_req.res.last    = drain_last;

        case (state_reg)
            mdd_pkg::ST_IDLE: begin
                if (s_valid && s_in_range) begin
                    fill_re    = 1'b1;
                    state_next = mdd_pkg::ST_LOOKUP;
                end
            end
            mdd_pkg::ST_LOOKUP: begin
                if (func_reg == mdd_pkg::FUNC_CLEAR) begin
                    fill_we    = 1'b1;
                    state_next = mdd_pkg::ST_IDLE;
                end else if (fill_now == FILL_W'(MSG_BYTES)) begin
                    state_next = mdd_pkg::ST_NOTICE;
                end else if (byte_reg != mdd_pkg::NUL_BYTE) begin
                    store_we   = 1'b1;
                    fill_we    = 1'b1;
                    fill_wdata = fill_now + FILL_W'(1);
                    state_next = mdd_pkg::ST_IDLE;
                end else if (fill_now == FILL_W'(0)) begin
                    state_next = mdd_pkg::ST_IDLE;
                end else begin
                    fill_we     = 1'b1;
                    fill_next   = fill_now;
                    idx_next    = POS_W'(0);
                    store_re    = 1'b1;
                    store_raddr = {ch_addr, POS_W'(0)};
                    state_next  = mdd_pkg::ST_DRAIN;
                end
            end
            mdd_pkg::ST_NOTICE: begin
                if (out_free) begin
                    out_req.load        = 1'b1;
                    out_req.res.kind    = mdd_pkg::KIND_DROP;
                    out_req.res.data    = 8'h00;
                    out_req.res.last    = 1'b1;
                    state_next          = mdd_pkg::ST_IDLE;
                end
            end
            mdd_pkg::ST_DRAIN: begin
                if (out_free) begin
                    out_req.load = 1'b1;
                    if (drain_last) begin
                        state_next = mdd_pkg::ST_IDLE;
                    end else begin
                        idx_next    = idx_reg + POS_W'(1);
                        store_re    = 1'b1;
                        store_raddr = {ch_addr, idx_reg + POS_W'(1)};
                    end
                end
            end
            default: begin
                state_next = mdd_pkg::ST_IDLE;
            end
        endcase

        if (fill_we) begin
            fvalid_next[ch_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mdd_pkg::ST_IDLE;
            fvalid_reg <= '0;
        end else begin
            state_reg  <= state_next;
            fvalid_reg <= fvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            ch_reg   <= s_channel;
            byte_reg <= s_data_byte;
        end
        fill_reg <= fill_next;
        idx_reg  <= idx_next;
    end

    a_drain_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mdd_pkg::ST_DRAIN |-> fill_reg != FILL_W'(0)
            && FILL_W'(idx_reg) < fill_reg)
        else $error("drain index outside stored message");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_req.load |-> out_free)
        else $error("result loaded over a pending beat");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_we |-> fill_wdata <= FILL_W'(MSG_BYTES))
        else $error("fill count written beyond store size");

    a_lookup_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mdd_pkg::ST_LOOKUP |-> $past(s_valid && s_ready))
        else $error("lookup without an accepted beat");

endmodule

@@ src/multichannel_nul_delimited_deframer.sv @@
// Top level of the multichannel NUL-delimited message deframer.
// Each input beat carries a byte or a clear for one channel. A data byte or clear is accepted,
// then follow the fill-count lookup and write-back in the fill RAM; a beat on a channel
// at or above NUM_CHANNELS is dropped in its accept cycle. A byte on a full channel yields a
// drop notice from the NOTICE state, once the output register is free. A NUL on a channel
// holding n bytes holds the input until drained: the store RAM read port delivers one
// message byte per cycle while the result channel is ready. No clearing pass is needed.
module multichannel_nul_delimited_deframer #(
    parameter int NUM_CHANNELS = mdd_pkg::NUM_CHANNELS_DEF,
    parameter int MSG_BYTES    = mdd_pkg::MSG_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [2:0] s_channel,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [2:0] m_out_channel,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W  = $clog2(MSG_BYTES);
    localparam int FILL_W = $clog2(MSG_BYTES + 1);
    localparam int SA_W   = CH_AW + POS_W;

    logic              fill_re;
    logic [CH_AW-1:0]  fill_raddr;
    logic [FILL_W-1:0] fill_rdata;
    logic              fill_we;
    logic [CH_AW-1:0]  fill_waddr;
    logic [FILL_W-1:0] fill_wdata;
    logic              store_re;
    logic [SA_W-1:0]   store_raddr;
    logic [7:0]        store_rdata;
    logic              store_we;
    logic [SA_W-1:0]   store_waddr;
    logic [7:0]        store_wdata;
    logic              out_free;
    mdd_pkg::out_req_t out_req;

    mdd_ram #(
        .WIDTH (FILL_W),
        .DEPTH (NUM_CHANNELS),
        .AW    (CH_AW)
    ) u_fill_ram (
        .aclk  (aclk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    mdd_ram #(
        .WIDTH (8),
        .DEPTH (NUM_CHANNELS << POS_W),
        .AW    (SA_W)
    ) u_store_ram (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    mdd_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MSG_BYTES    (MSG_BYTES),
        .CH_AW        (CH_AW),
        .POS_W        (POS_W),
        .FILL_W       (FILL_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_channel   (s_channel),
        .s_data_byte (s_data_byte),
        .fill_re     (fill_re),
        .fill_raddr  (fill_raddr),
        .fill_rdata  (fill_rdata),
        .fill_we     (fill_we),
        .fill_waddr  (fill_waddr),
        .fill_wdata  (fill_wdata),
        .store_re    (store_re),
        .store_raddr (store_raddr),
        .store_rdata (store_rdata),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .out_free    (out_free),
        .out_req     (out_req)
    );

    mdd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .out_req       (out_req),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_out_channel (m_out_channel),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last)
    );

endmodule

@@ sim/tb_multichannel_nul_delimited_deframer.sv @@
// Self-checking testbench for the multichannel NUL-delimited deframer.
module tb_multichannel_nul_delimited_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS   = mdd_pkg::NUM_CHANNELS_DEF;
    localparam int STORE_LEN  = mdd_pkg::MSG_BYTES_DEF;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 100000;
    localparam int SETTLE     = 12;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic       s_func        = mdd_pkg::FUNC_DATA;
    logic [2:0] s_channel     = 3'd0;
    logic [7:0] s_data_byte   = mdd_pkg::NUL_BYTE;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_kind;
    logic [2:0] m_out_channel;
    logic [7:0] m_out_byte;
    logic       m_last;

    logic [7:0]       chan_bytes [CHANNELS][STORE_LEN];
    int               chan_fill  [CHANNELS];
    mdd_pkg::result_t deframed_q [$];

    int mismatches    = 0;
    int beats_sent    = 0;
    int hold_requests = 0;
    bit idling_on     = 1'b1;

    multichannel_nul_delimited_deframer #(
        .NUM_CHANNELS(CHANNELS),
        .MSG_BYTES   (STORE_LEN)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_channel    (s_channel),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_channel(m_out_channel),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[multichannel_nul_delimited_deframer] ERROR");
        $finish;
    end

    task automatic report_mismatch(string what);
        if (mismatches < 40) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic void deframe_beat(logic f, logic [2:0] ch, logic [7:0] b);
        mdd_pkg::result_t r;
        int fill;
        if (int'(ch) >= CHANNELS) return;
        if (f == mdd_pkg::FUNC_CLEAR) begin
            chan_fill[ch] = 0;
            return;
        end
        fill = chan_fill[ch];
        if (fill >= STORE_LEN) begin
            r.kind    = mdd_pkg::KIND_DROP;
            r.channel = ch;
            r.data    = 8'h00;
            r.last    = 1'b1;
            deframed_q = {deframed_q, r};
            return;
        end
        if (b != mdd_pkg::NUL_BYTE) begin
            chan_bytes[ch][fill] = b;
            chan_fill[ch] = fill + 1;
            return;
        end
        for (int i = 0; i < fill; i++) begin
            r.kind    = mdd_pkg::KIND_MSG;
            r.channel = ch;
            r.data    = chan_bytes[ch][i];
            r.last    = (i == fill - 1);
            deframed_q = {deframed_q, r};
        end
        chan_fill[ch] = 0;
    endfunction

    // Hold the payload until the beat is taken; lower valid only for a gap.
    task automatic send_beat(logic f, logic [2:0] ch, logic [7:0] b);
        int gap;
        gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_channel   <= ch;
        s_data_byte <= b;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        deframe_beat(f, ch, b);
        beats_sent++;
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (deframed_q.size() != 0 && n < DRAIN_WAIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic fill_channel(logic [2:0] ch, int n);
        for (int i = 0; i < n; i++) begin
            send_beat(mdd_pkg::FUNC_DATA, ch, 8'($urandom_range(1, 255)));
        end
    endtask

    // Receiver: random stall bursts, plus a long hold-off on request.
    initial begin
        int idle_left;
        int hold_left;
        int hold_served;
        idle_left   = 0;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        mdd_pkg::result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (deframed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0b ch %0d byte %02h last %0b",
                    m_kind, m_out_channel, m_out_byte, m_last));
            end else begin
                want = deframed_q.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch($sformatf("kind %0b, want %0b", m_kind, want.kind));
                if (m_out_channel !== want.channel)
                    report_mismatch($sformatf("channel %0d, want %0d",
                        m_out_channel, want.channel));
                if (m_out_byte !== want.data)
                    report_mismatch($sformatf("byte %02h, want %02h", m_out_byte, want.data));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
            end
        end
    end

    task automatic test_directed();
        send_beat(mdd_pkg::FUNC_DATA, 3'd0, 8'h01);
        send_beat(mdd_pkg::FUNC_DATA, 3'd0, 8'hFF);
        send_beat(mdd_pkg::FUNC_DATA, 3'd0, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd7, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd5, 8'h80);
        send_beat(mdd_pkg::FUNC_DATA, 3'd5, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd2, 8'h41);
        send_beat(mdd_pkg::FUNC_DATA, 3'd6, 8'h7F);
        send_beat(mdd_pkg::FUNC_DATA, 3'd2, 8'h42);
        send_beat(mdd_pkg::FUNC_DATA, 3'd6, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd2, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd1, 8'h55);
        send_beat(mdd_pkg::FUNC_CLEAR, 3'd1, 8'hFF);
        send_beat(mdd_pkg::FUNC_DATA, 3'd1, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_CLEAR, 3'd4, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd3, 8'hAA);
        send_beat(mdd_pkg::FUNC_DATA, 3'd3, 8'h01);
        send_beat(mdd_pkg::FUNC_DATA, 3'd3, 8'hFE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd3, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd7, 8'h5A);
        send_beat(mdd_pkg::FUNC_DATA, 3'd7, mdd_pkg::NUL_BYTE);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_store_limits();
        fill_channel(3'd4, STORE_LEN - 1);
        send_beat(mdd_pkg::FUNC_DATA, 3'd4, mdd_pkg::NUL_BYTE);
        fill_channel(3'd6, STORE_LEN);
        send_beat(mdd_pkg::FUNC_DATA, 3'd6, 8'h33);
        send_beat(mdd_pkg::FUNC_DATA, 3'd6, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_DATA, 3'd1, 8'h11);
        send_beat(mdd_pkg::FUNC_DATA, 3'd6, 8'hFF);
        send_beat(mdd_pkg::FUNC_DATA, 3'd1, mdd_pkg::NUL_BYTE);
        send_beat(mdd_pkg::FUNC_CLEAR, 3'd6, 8'h00);
        send_beat(mdd_pkg::FUNC_DATA, 3'd6, 8'h10);
        send_beat(mdd_pkg::FUNC_DATA, 3'd6, mdd_pkg::NUL_BYTE);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_traffic(int n);
        int goal;
        int r;
        logic [2:0] ch;
        goal = beats_sent + n;
        while (beats_sent < goal) begin
            ch = 3'($urandom_range(0, CHANNELS - 1));
            r  = $urandom_range(0, 99);
            if (r == 0) begin
                fill_channel(ch, $urandom_range(STORE_LEN - 4, STORE_LEN + 2));
                send_beat(mdd_pkg::FUNC_DATA, ch, mdd_pkg::NUL_BYTE);
            end else if (r < 8) begin
                send_beat(mdd_pkg::FUNC_CLEAR, ch, 8'($urandom_range(0, 255)));
            end else if (r < 30) begin
                send_beat(mdd_pkg::FUNC_DATA, ch, mdd_pkg::NUL_BYTE);
            end else begin
                send_beat(mdd_pkg::FUNC_DATA, ch, 8'($urandom_range(1, 255)));
            end
        end
        stop_sending();
        wait_drained();
    endtask

    // Hold the receiver off while whole messages keep arriving.
    task automatic test_backpressure();
        hold_requests++;
        for (int m = 0; m < 6; m++) begin
            fill_channel(3'(m), $urandom_range(3, 8));
            send_beat(mdd_pkg::FUNC_DATA, 3'(m), mdd_pkg::NUL_BYTE);
        end
        stop_sending();
        wait_drained();
    endtask

    initial begin
        for (int c = 0; c < CHANNELS; c++) chan_fill[c] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_store_limits();
        test_random_traffic(120);
        test_backpressure();
        idling_on = 1'b0;
        test_random_traffic(60);

        if (deframed_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected beats never arrived", deframed_q.size()));
        end
        if (mismatches == 0) begin
            $display("[multichannel_nul_delimited_deframer] OK");
        end else begin
            $display("[multichannel_nul_delimited_deframer] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/mdd_pkg.sv
src/mdd_ram.sv
src/mdd_out_stage.sv
src/mdd_ctrl.sv
src/multichannel_nul_delimited_deframer.sv
sim/tb_multichannel_nul_delimited_deframer.sv
